/* design/bra_pkg.sv */
// Shared constants, codes and types of the bitmap run allocator.
// Used by bra_word_scan and bitmap_run_allocator; depends on nothing.
package bra_pkg;

	localparam int BLOCKS_PER_PAGE = 256;
	localparam int NUM_PAGES       = 4;
	localparam int BLOCK_BYTES     = 16;

	localparam int BLK_W      = 8;   // block index and run length fields
	localparam int PAGE_W     = 2;   // page field
	localparam int OPEN_W     = 3;   // count of opened pages, up to NUM_PAGES
	localparam int SIZE_W     = 12;
	localparam int BYTE_SHIFT = $clog2(BLOCK_BYTES);

	localparam int WORD_BITS  = 8;
	localparam int NUM_WORDS  = BLOCKS_PER_PAGE / WORD_BITS;
	localparam int WORD_IDX_W = $clog2(NUM_WORDS);
	localparam int WORD_SH    = $clog2(WORD_BITS);

	localparam int LEN_DEPTH  = NUM_PAGES * BLOCKS_PER_PAGE;
	localparam int LEN_ADDR_W = $clog2(LEN_DEPTH);

	localparam logic [SIZE_W-1:0] LARGE_LIMIT = SIZE_W'(13'h1000 - 13'h010);

	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_NO_RUN   = 2'd1;
	localparam logic [1:0] ST_BAD_FREE = 2'd2;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// running state of the first-fit search, carried from word to word
	typedef struct packed {
		logic [BLK_W-1:0] cnt;
		logic             found;
		logic [BLK_W-1:0] start;
	} scan_t;

endpackage

/* design/bra_word_scan.sv */
// One step of the first-fit search: walks one word of the used map.
// Depends on bra_pkg for widths and the scan_t state record.
module bra_word_scan (
	input  logic [bra_pkg::WORD_BITS-1:0] word,
	input  logic [bra_pkg::BLK_W-1:0]     base,
	input  logic [bra_pkg::BLK_W-1:0]     need,
	input  bra_pkg::scan_t                st_in,
	output bra_pkg::scan_t                st_out
);

	bra_pkg::scan_t st;

	always_comb begin
		st = st_in;
		for (int i = 0; i < bra_pkg::WORD_BITS; i++) begin
			if (!st.found) begin
				if (!word[i]) begin
					st.cnt = st.cnt + bra_pkg::BLK_W'(1);
					if (st.cnt == need) begin
						st.found = 1'b1;
						// run ends at this bit: start = index + 1 - need
						st.start = bra_pkg::BLK_W'(base + bra_pkg::BLK_W'(i)
							+ bra_pkg::BLK_W'(1) - need);
					end
				end else begin
					st.cnt = '0;
				end
			end
		end
	end

	assign st_out = st;

endmodule

/* design/bitmap_run_allocator.sv */
// Bitmap run allocator: first-fit allocation and freeing of block runs.
// Depends on bra_pkg and instantiates bra_word_scan.
//
//  port group  dir  carries
//  ----------  ---  --------------------------------------------------
//  s_*         in   request word: kind in tuser, size / page / block
//  m_*         out  result word: status in tuser, page / start / length
//
// After reset the length store is swept to zero, one entry a cycle, and no
// request is taken until the sweep is done.
// An allocate: the accept, a scan of one 8-bit word of the used map a cycle
// until the run is found (32 words a page) or, at the page end, the next page
// opens (no page left: no mark), a mark, the issue; a page-sized request skips
// to the issue. A free: accept with length store read, check, clear, issue;
// a refused free skips the clear.
// One request is in flight at a time; a finished result waits in the
// output register, so the next request is accepted while it is unread,
// and its issue holds until that word has been read.
module bitmap_run_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [11:0] size_bytes, [13:12] free_page,
	                              // [21:14] free_block, [23:22] zero
	input  logic [0:0]  s_tuser,  // [0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [1:0] run_page, [9:2] run_start,
	                              // [17:10] run_blocks, [23:18] zero
	output logic [1:0]  m_tuser   // [1:0] status
);

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_SCAN  = 7'b0000100,
		S_CHECK = 7'b0001000,
		S_MARK  = 7'b0010000,
		S_EMIT  = 7'b0100000,
		S_SPARE = 7'b1000000
	} state_t;

	state_t state_q;

	// control state
	logic [bra_pkg::NUM_PAGES-1:0][bra_pkg::BLOCKS_PER_PAGE-1:0] used_q;
	logic [bra_pkg::PAGE_W-1:0]     cur_page_q;
	logic [bra_pkg::OPEN_W-1:0]     pages_open_q;
	logic [bra_pkg::LEN_ADDR_W-1:0] clr_cnt_q;
	logic                           m_tvalid_q;

	// datapath
	logic [bra_pkg::BLK_W-1:0]      len_mem [bra_pkg::LEN_DEPTH];
	logic [bra_pkg::BLK_W-1:0]      rd_q;
	logic [bra_pkg::PAGE_W-1:0]     op_page_q;
	logic [bra_pkg::BLK_W-1:0]      op_start_q;
	logic [bra_pkg::BLK_W-1:0]      op_len_q;
	logic                           op_free_q;
	logic [bra_pkg::WORD_IDX_W-1:0] word_q;
	bra_pkg::scan_t                 scan_q;
	bra_pkg::scan_t                 scan_d;
	logic [1:0]                     res_status_q;
	logic [bra_pkg::PAGE_W-1:0]     res_page_q;
	logic [bra_pkg::BLK_W-1:0]      res_start_q;
	logic [bra_pkg::BLK_W-1:0]      res_blocks_q;
	logic [23:0]                    m_tdata_q;
	logic [1:0]                     m_tuser_q;

	// request fields
	logic                          in_req;
	logic [bra_pkg::SIZE_W-1:0]    in_size;
	logic [bra_pkg::PAGE_W-1:0]    in_page;
	logic [bra_pkg::BLK_W-1:0]     in_block;
	logic [bra_pkg::BLK_W:0]       in_need;
	logic                          in_large;
	logic                          accept;
	logic                          out_free;

	logic [bra_pkg::WORD_BITS-1:0] cur_word;
	logic [bra_pkg::BLK_W-1:0]     word_base;
	logic                          last_word;
	logic                          free_bad;

	logic [bra_pkg::BLOCKS_PER_PAGE-1:0] run_mask;
	logic [bra_pkg::BLK_W:0]             run_end;

	logic                           mem_we;
	logic [bra_pkg::LEN_ADDR_W-1:0] mem_waddr;
	logic [bra_pkg::BLK_W-1:0]      mem_wdata;

	assign in_req   = s_tuser[0];
	assign in_size  = s_tdata[11:0];
	assign in_page  = s_tdata[13:12];
	assign in_block = s_tdata[21:14];
	assign in_need  = (bra_pkg::BLK_W + 1)'(in_size >> bra_pkg::BYTE_SHIFT)
		+ (bra_pkg::BLK_W + 1)'(1);
	// page-sized request, or a run that cannot fit beside block zero
	assign in_large = (in_size >= bra_pkg::LARGE_LIMIT)
		|| (in_need > (bra_pkg::BLK_W + 1)'(bra_pkg::BLOCKS_PER_PAGE - 1));

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// search unit: one used-map word a cycle, run count carried across words
	assign word_base = bra_pkg::BLK_W'({word_q, {bra_pkg::WORD_SH{1'b0}}});
	assign cur_word  = used_q[op_page_q][word_base +: bra_pkg::WORD_BITS];
	assign last_word = (word_q == bra_pkg::WORD_IDX_W'(bra_pkg::NUM_WORDS - 1));

	bra_word_scan u_scan (
		.word   (cur_word),
		.base   (word_base),
		.need   (op_len_q),
		.st_in  (scan_q),
		.st_out (scan_d)
	);

	// free is refused for an unopened page, block zero, or no recorded run
	assign free_bad = ({1'b0, op_page_q} >= pages_open_q)
		|| ({1'b0, op_page_q} >= bra_pkg::OPEN_W'(bra_pkg::NUM_PAGES))
		|| (op_start_q == '0) || (rd_q == '0);

	// blocks start .. start+len-1 of the page being marked or cleared
	assign run_end = {1'b0, op_start_q} + {1'b0, op_len_q};
	always_comb begin
		for (int b = 0; b < bra_pkg::BLOCKS_PER_PAGE; b++) begin
			run_mask[b] = ((bra_pkg::BLK_W + 1)'(b) >= {1'b0, op_start_q})
				&& ((bra_pkg::BLK_W + 1)'(b) < run_end);
		end
	end

	// length store write port: sweep after reset, then record or erase runs
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = {op_page_q, op_start_q};
		mem_wdata = op_free_q ? '0 : op_len_q;
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_cnt_q;
			mem_wdata = '0;
		end else if (state_q == S_MARK) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			len_mem[mem_waddr] <= mem_wdata;
		end
		// look up the run length as a free is taken
		if (accept) begin
			rd_q <= len_mem[{in_page, in_block}];
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			cur_page_q   <= '0;
			pages_open_q <= bra_pkg::OPEN_W'(1);
			clr_cnt_q    <= '0;
			m_tvalid_q   <= 1'b0;
			for (int p = 0; p < bra_pkg::NUM_PAGES; p++) begin
				used_q[p] <= bra_pkg::BLOCKS_PER_PAGE'(1);
			end
		end else begin
			// drop valid once read, unless a new word is issued this cycle
			if (m_tvalid_q && m_tready && state_q != S_EMIT) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + bra_pkg::LEN_ADDR_W'(1);
					if (clr_cnt_q == bra_pkg::LEN_ADDR_W'(bra_pkg::LEN_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (in_req == bra_pkg::REQ_FREE) begin
							state_q <= S_CHECK;
						end else if (in_large) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_d.found) begin
						state_q <= S_MARK;
					end else if (last_word) begin
						if (pages_open_q >= bra_pkg::OPEN_W'(bra_pkg::NUM_PAGES)) begin
							state_q <= S_EMIT;
						end else begin
							// open the next page and make it current
							cur_page_q   <= bra_pkg::PAGE_W'(pages_open_q);
							pages_open_q <= pages_open_q + bra_pkg::OPEN_W'(1);
							state_q      <= S_MARK;
						end
					end
				end
				S_CHECK: begin
					state_q <= free_bad ? S_EMIT : S_MARK;
				end
				S_MARK: begin
					if (op_free_q) begin
						used_q[op_page_q] <= used_q[op_page_q] & ~run_mask;
					end else begin
						used_q[op_page_q] <= used_q[op_page_q] | run_mask;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					// hold until the output register is free
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// operand and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_free_q    <= (in_req == bra_pkg::REQ_FREE);
			op_page_q    <= (in_req == bra_pkg::REQ_FREE) ? in_page : cur_page_q;
			op_start_q   <= in_block;
			op_len_q     <= in_need[bra_pkg::BLK_W-1:0];
			word_q       <= '0;
			scan_q       <= '0;
			res_status_q <= bra_pkg::ST_NO_RUN;
			res_page_q   <= '0;
			res_start_q  <= '0;
			res_blocks_q <= '0;
		end
		if (state_q == S_SCAN) begin
			word_q <= word_q + bra_pkg::WORD_IDX_W'(1);
			scan_q <= scan_d;
			if (scan_d.found) begin
				op_start_q <= scan_d.start;
			end else if (last_word) begin
				// a fresh page has only block zero used: the run starts at one
				op_page_q  <= bra_pkg::PAGE_W'(pages_open_q);
				op_start_q <= bra_pkg::BLK_W'(1);
			end
		end
		if (state_q == S_CHECK) begin
			op_len_q <= rd_q;
			if (free_bad) begin
				res_status_q <= bra_pkg::ST_BAD_FREE;
			end
		end
		if (state_q == S_MARK) begin
			res_status_q <= bra_pkg::ST_DONE;
			res_page_q   <= op_page_q;
			res_start_q  <= op_start_q;
			res_blocks_q <= op_len_q;
		end
		if (state_q == S_EMIT && out_free) begin
			m_tuser_q <= res_status_q;
			m_tdata_q <= {6'b0, res_blocks_q, res_start_q, res_page_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

/* tb/bra_result_monitor.sv */
// Result monitor for the bitmap run allocator: predicts each result and compares it.
// Depends on bra_pkg; watches the request and result streams beside the block.
module bra_result_monitor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,  // [11:0] size_bytes, [13:12] free_page,
	                              // [21:14] free_block, [23:22] zero
	input  logic [0:0]  s_tuser,  // [0] req_type
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,  // [1:0] run_page, [9:2] run_start,
	                              // [17:10] run_blocks, [23:18] zero
	input  logic [1:0]  m_tuser,  // [1:0] status
	output int          mismatches,
	output int          pending
);

	typedef struct packed {
		logic [1:0]                 status;
		logic [bra_pkg::PAGE_W-1:0] page;
		logic [bra_pkg::BLK_W-1:0]  start;
		logic [bra_pkg::BLK_W-1:0]  blocks;
	} outcome_t;

	// shadow of the allocator state
	logic [bra_pkg::BLOCKS_PER_PAGE-1:0] block_used [bra_pkg::NUM_PAGES];
	logic [bra_pkg::BLK_W-1:0] run_len [bra_pkg::NUM_PAGES][bra_pkg::BLOCKS_PER_PAGE];
	logic [bra_pkg::PAGE_W-1:0] cur_page;
	logic [bra_pkg::OPEN_W-1:0] open_pages;

	outcome_t due_results [$];

	// lowest start of n free blocks in a row, 0 when none (block zero is never free)
	function automatic int first_fit(input int pg, input int n);
		int count;
		count = 0;
		for (int b = 0; b < bra_pkg::BLOCKS_PER_PAGE; b++) begin
			if (!block_used[pg][b]) begin
				count++;
				if (count == n)
					return b + 1 - n;
			end else begin
				count = 0;
			end
		end
		return 0;
	endfunction

	task automatic allocate_or_free(input logic kind,
			input logic [bra_pkg::SIZE_W-1:0] size,
			input logic [bra_pkg::PAGE_W-1:0] pg_in,
			input logic [bra_pkg::BLK_W-1:0] blk_in,
			output outcome_t res);
		int n;
		int pg;
		int start;
		res = '0;
		if (kind == bra_pkg::REQ_ALLOC) begin
			n = int'(size) / bra_pkg::BLOCK_BYTES + 1;
			pg = int'(cur_page);
			start = 0;
			// page-sized requests and over-long runs fail without touching anything
			if (size < bra_pkg::LARGE_LIMIT && n <= bra_pkg::BLOCKS_PER_PAGE - 1) begin
				start = first_fit(pg, n);
				// open the next page only while one is left; older pages are not revisited
				if (start == 0 && int'(open_pages) < bra_pkg::NUM_PAGES) begin
					pg = int'(open_pages);
					cur_page = bra_pkg::PAGE_W'(pg);
					open_pages = open_pages + bra_pkg::OPEN_W'(1);
					start = first_fit(pg, n);
				end
			end
			if (start != 0) begin
				for (int b = start; b < start + n && b < bra_pkg::BLOCKS_PER_PAGE; b++)
					block_used[pg][b] = 1'b1;
				run_len[pg][start] = bra_pkg::BLK_W'(n);
				res.status = bra_pkg::ST_DONE;
				res.page = bra_pkg::PAGE_W'(pg);
				res.start = bra_pkg::BLK_W'(start);
				res.blocks = bra_pkg::BLK_W'(n);
			end else begin
				res.status = bra_pkg::ST_NO_RUN;
			end
		end else begin
			if (int'(pg_in) >= int'(open_pages) || blk_in == '0
					|| run_len[pg_in][blk_in] == '0) begin
				res.status = bra_pkg::ST_BAD_FREE;
			end else begin
				n = int'(run_len[pg_in][blk_in]);
				for (int b = int'(blk_in); b < int'(blk_in) + n
						&& b < bra_pkg::BLOCKS_PER_PAGE; b++)
					block_used[pg_in][b] = 1'b0;
				run_len[pg_in][blk_in] = '0;
				res.status = bra_pkg::ST_DONE;
				res.page = pg_in;
				res.start = blk_in;
				res.blocks = bra_pkg::BLK_W'(n);
			end
		end
	endtask

	always @(posedge clk) begin : watch
		outcome_t want;
		outcome_t got;
		if (!arst_n) begin
			for (int p = 0; p < bra_pkg::NUM_PAGES; p++) begin
				block_used[p] = '0;
				block_used[p][0] = 1'b1;
				for (int b = 0; b < bra_pkg::BLOCKS_PER_PAGE; b++)
					run_len[p][b] = '0;
			end
			cur_page = '0;
			open_pages = bra_pkg::OPEN_W'(1);
			due_results.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			// retire before predicting, so a word taken this edge is not matched early
			if (m_tvalid && m_tready) begin
				got.status = m_tuser;
				got.page = m_tdata[1:0];
				got.start = m_tdata[9:2];
				got.blocks = m_tdata[17:10];
				if (due_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("no result due: status %0d page %0d start %0d blocks %0d",
							got.status, got.page, got.start, got.blocks);
				end else begin
					want = due_results.pop_front();
					if (got != want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$write("mismatch: expected status %0d page %0d start %0d blocks %0d",
								want.status, want.page, want.start, want.blocks);
							$display(", got status %0d page %0d start %0d blocks %0d",
								got.status, got.page, got.start, got.blocks);
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				allocate_or_free(s_tuser[0], s_tdata[11:0], s_tdata[13:12],
					s_tdata[21:14], want);
				due_results.push_back(want);
			end
			pending <= due_results.size();
		end
	end

endmodule

/* tb/testbench.sv */
// Top of the bitmap run allocator regression: clock, reset, request stimulus, verdict.
// Depends on bra_pkg, bitmap_run_allocator and bra_result_monitor.
module testbench;

	localparam int RANDOM_WORDS = 850;
	localparam int CYCLE_LIMIT  = 400000;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;  // [11:0] size_bytes, [13:12] free_page,
	                             // [21:14] free_block, [23:22] zero
	logic [0:0]  s_tuser  = '0;  // [0] req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // [1:0] run_page, [9:2] run_start,
	                             // [17:10] run_blocks, [23:18] zero
	logic [1:0]  m_tuser;        // [1:0] status

	int mismatches;
	int pending;
	int cycles = 0;

	// idling switch shared with the result side; the sender keeps its own copy
	logic idling = 1'b0;
	logic idle_now = 1'b0;
	int   stall_left = 0;

	// kinds of accepted request words, oldest first, and runs believed live
	logic       sent_kinds [$];
	logic [9:0] live_runs [$];   // [1:0] page, [9:2] start block

	always #1 clk = ~clk;

	bitmap_run_allocator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	bra_result_monitor u_monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// Result side: stall in bursts of random length while idling is on.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idling && $urandom_range(0, 11) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 4);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Remember where successful allocations landed, so frees can aim at real runs.
	always @(posedge clk) begin : note_runs
		logic kind;
		if (m_tvalid && m_tready && sent_kinds.size() != 0) begin
			kind = sent_kinds.pop_front();
			if (kind == bra_pkg::REQ_ALLOC && m_tuser == bra_pkg::ST_DONE)
				live_runs.push_back(m_tdata[9:0]);
		end
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("bitmap_run_allocator regression: fail");
			$finish;
		end
	end

	// Offer one request word and hold it until the block takes it;
	// while idling, sometimes drop valid for a short burst first.
	task automatic send_word(input logic kind, input logic [bra_pkg::SIZE_W-1:0] size,
			input logic [bra_pkg::PAGE_W-1:0] pg, input logic [bra_pkg::BLK_W-1:0] blk);
		int gap;
		if (idle_now && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 5);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {2'b00, blk, pg, size};
		do @(posedge clk); while (!s_tready);
		sent_kinds.push_back(kind);
	endtask

	// Hold the sender until every outstanding result has been read.
	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin : stimulus
		int pick;
		int idx;
		logic [9:0]                 run;
		logic [bra_pkg::SIZE_W-1:0] size_r;
		logic [bra_pkg::PAGE_W-1:0] pg_r;
		logic [bra_pkg::BLK_W-1:0]  blk_r;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// smallest runs, then the one-block / two-block boundary
		send_word(bra_pkg::REQ_ALLOC, 12'd0, '0, '0);
		send_word(bra_pkg::REQ_ALLOC, 12'd15, '0, '0);
		send_word(bra_pkg::REQ_ALLOC, 12'd16, '0, '0);
		// page-sized requests
		send_word(bra_pkg::REQ_ALLOC, 12'd4080, '0, '0);
		send_word(bra_pkg::REQ_ALLOC, 12'hFFF, 2'd3, 8'hFF);
		// a good free, then the bad ones: repeat, block zero, unopened page, no run
		send_word(bra_pkg::REQ_FREE, 12'd0, 2'd0, 8'd3);
		send_word(bra_pkg::REQ_FREE, 12'd0, 2'd0, 8'd3);
		send_word(bra_pkg::REQ_FREE, 12'hFFF, 2'd0, 8'd0);
		send_word(bra_pkg::REQ_FREE, 12'd0, 2'd3, 8'hFF);
		send_word(bra_pkg::REQ_FREE, 12'd0, 2'd0, 8'hFF);
		// refill the hole first-fit, free the first run
		send_word(bra_pkg::REQ_ALLOC, 12'd16, '0, '0);
		send_word(bra_pkg::REQ_FREE, 12'd0, 2'd0, 8'd1);
		// longest run that fits: forces a new page
		send_word(bra_pkg::REQ_ALLOC, 12'd4079, '0, '0);
		send_word(bra_pkg::REQ_FREE, 12'd0, 2'd1, 8'd1);
		// big runs until every page is open and the search runs dry
		send_word(bra_pkg::REQ_ALLOC, 12'd4000, '0, '0);
		send_word(bra_pkg::REQ_ALLOC, 12'd4000, '0, '0);
		send_word(bra_pkg::REQ_ALLOC, 12'd4000, '0, '0);
		send_word(bra_pkg::REQ_ALLOC, 12'd4000, '0, '0);
		send_word(bra_pkg::REQ_ALLOC, 12'd0, '0, '0);
		// space freed on an older page is not searched again
		send_word(bra_pkg::REQ_FREE, 12'd0, 2'd2, 8'd1);
		send_word(bra_pkg::REQ_ALLOC, 12'd4000, '0, '0);
		send_word(bra_pkg::REQ_FREE, 12'd0, 2'd3, 8'd1);
		send_word(bra_pkg::REQ_FREE, 12'd0, 2'd3, 8'd252);
		send_word(bra_pkg::REQ_ALLOC, 12'd63, '0, '0);

		for (int k = 0; k < RANDOM_WORDS; k++) begin
			if (k == 0 || k == 400)
				hold_until_drained();
			// quiet tail; otherwise toggle idling now and then
			if (k >= RANDOM_WORDS - 120)
				idle_now = 1'b0;
			else if (k == 0 || $urandom_range(0, 39) == 0)
				idle_now = (k == 0) ? 1'b1 : !idle_now;
			idling <= idle_now;

			// ignored fields still carry random bits
			size_r = bra_pkg::SIZE_W'($urandom);
			pg_r = bra_pkg::PAGE_W'($urandom);
			blk_r = bra_pkg::BLK_W'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				send_word(bra_pkg::REQ_FREE, size_r, pg_r, blk_r);
			end else if (pick < 50 && live_runs.size() != 0) begin
				idx = $urandom_range(0, live_runs.size() - 1);
				run = live_runs[idx];
				live_runs.delete(idx);
				send_word(bra_pkg::REQ_FREE, size_r, run[1:0], run[9:2]);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 55)
					size_r = bra_pkg::SIZE_W'($urandom_range(0, 127));
				else if (pick < 85)
					size_r = bra_pkg::SIZE_W'($urandom_range(128, 1023));
				else if (pick < 96)
					size_r = bra_pkg::SIZE_W'($urandom_range(1024, 4079));
				else
					size_r = bra_pkg::SIZE_W'($urandom_range(4080, 4095));
				send_word(bra_pkg::REQ_ALLOC, size_r, pg_r, blk_r);
			end
		end

		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		// allow a stray late word to show up
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("bitmap_run_allocator regression: pass");
		else
			$display("bitmap_run_allocator regression: fail");
		$finish;
	end

endmodule
